// ===== hdl/dic_pkg.sv =====
// shared constants, codes and types of the dynamic inversion counter
package dic_pkg;

  localparam int MaxLen = 1024;
  localparam int LenW = $clog2(MaxLen);
  localparam int CntW = LenW + 1;
  localparam int ValW = 11;
  localparam int InvW = 19;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_APPEND = 2'd1,
    ERR_ABSENT = 2'd2,
    ERR_UNUSED = 2'd3
  } err_e;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            present;
  } slot_t;

  typedef struct packed {
    logic live;
    logic gt;
    logic lt;
    logic eq;
  } cmp_t;

endpackage

// ===== hdl/dic_cell.sv =====
// one slot of the rotating slot ring
module dic_cell import dic_pkg::*; (
  input  logic  clk_i,
  input  logic  shift_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  slot_t slot_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== hdl/dic_cmp.sv =====
// compare unit at the head of the ring
module dic_cmp import dic_pkg::*; (
  input  slot_t           head_i,
  input  logic [LenW-1:0] step_i,
  input  logic [CntW-1:0] slot_cnt_i,
  input  logic [ValW-1:0] value_i,
  output cmp_t            cmp_o
);

  always_comb begin
    cmp_o.live = head_i.present && ({1'b0, step_i} < slot_cnt_i);
    cmp_o.gt   = head_i.value > value_i;
    cmp_o.lt   = head_i.value < value_i;
    cmp_o.eq   = head_i.value == value_i;
  end

endmodule

// ===== hdl/dynamic_inversion_counter.sv =====
// top level: slot ring, head compare and scan control of the inversion counter
// clear and unused kinds, rejected values and a full store: result valid in the cycle after request
// append and delete: the ring rotates once past the head compare, result registered at the end of the scan
// one request at a time: no new request is taken while a scan runs or an unaccepted result is held
// reset (async, active low) empties the store and zeroes the count; slot cells are not reset
module dynamic_inversion_counter import dic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // value[10:0], zero fill
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // inversions[18:0], error[20:19], zero fill
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_e;

  state_e          state_q;
  logic [LenW-1:0] step_q;
  logic [CntW-1:0] slot_cnt_q;
  logic [InvW-1:0] total_q;
  logic [ValW-1:0] value_q;
  logic            is_app_q;
  logic            hit_q;
  logic            hit_d;
  logic [CntW-1:0] cnt_a_q;
  logic [CntW-1:0] cnt_a_d;
  logic [CntW-1:0] cnt_b_q;
  logic [CntW-1:0] cnt_b_d;
  logic            out_valid_q;
  logic [InvW-1:0] out_inv_q;
  err_e            out_err_q;

  slot_t ring [MaxLen];
  slot_t feed;
  cmp_t  cmp;
  logic  shift;
  logic  req;
  logic  [ValW-1:0] in_value;
  kind_e in_kind;
  logic  range_ok;
  logic  last_step;
  logic  scan_go;
  logic  res_set;
  logic  [CntW-1:0] sub;

  assign in_value = s_axis_tdata[ValW-1:0];
  assign in_kind  = kind_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign req = s_axis_tvalid && s_axis_tready;
  assign range_ok = (in_value != '0) && (32'(in_value) <= 32'(MaxLen));
  assign shift = (state_q == ST_SCAN);
  assign last_step = (step_q == LenW'(MaxLen - 1));
  assign scan_go = ((in_kind == KIND_APPEND) && range_ok && (slot_cnt_q != CntW'(MaxLen))) ||
                   ((in_kind == KIND_DELETE) && range_ok);
  assign res_set = (state_q == ST_SCAN) ? last_step : (req && !scan_go);
  assign sub = cnt_a_d + cnt_b_d;

  for (genvar i = 0; i < MaxLen; i++) begin : g_ring
    dic_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .slot_i (i == MaxLen - 1 ? feed : ring[(i + 1) % MaxLen]),
      .slot_o (ring[i])
    );
  end

  dic_cmp u_cmp (
    .head_i    (ring[0]),
    .step_i    (step_q),
    .slot_cnt_i(slot_cnt_q),
    .value_i   (value_q),
    .cmp_o     (cmp)
  );

  always_comb begin
    feed = ring[0];
    if (is_app_q) begin
      if (({1'b0, step_q} == slot_cnt_q) && !hit_q) begin
        feed.value   = value_q;
        feed.present = 1'b1;
      end
    end else if (cmp.live && cmp.eq) begin
      feed.present = 1'b0;
    end
  end

  // counts including the slot at the head in this cycle
  always_comb begin
    hit_d   = hit_q;
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    if (cmp.live && cmp.eq) begin
      hit_d = 1'b1;
    end
    if (is_app_q) begin
      if (cmp.live && cmp.gt) begin
        cnt_a_d = cnt_a_q + 1'b1;
      end
    end else begin
      if (!hit_q && cmp.live && cmp.gt) begin
        cnt_a_d = cnt_a_q + 1'b1;
      end
      if (hit_q && cmp.live && cmp.lt) begin
        cnt_b_d = cnt_b_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      slot_cnt_q  <= '0;
      total_q     <= '0;
      value_q     <= '0;
      is_app_q    <= 1'b0;
      hit_q       <= 1'b0;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      out_valid_q <= 1'b0;
      out_inv_q   <= '0;
      out_err_q   <= ERR_OK;
    end else begin
      if (res_set) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req) begin
            value_q  <= in_value;
            is_app_q <= (in_kind == KIND_APPEND);
            hit_q    <= 1'b0;
            cnt_a_q  <= '0;
            cnt_b_q  <= '0;
            step_q   <= '0;
            case (in_kind)
              KIND_CLEAR: begin
                slot_cnt_q  <= '0;
                total_q     <= '0;
                out_inv_q   <= '0;
                out_err_q   <= ERR_OK;
              end
              KIND_APPEND: begin
                if (!range_ok || slot_cnt_q == CntW'(MaxLen)) begin
                  out_inv_q   <= total_q;
                  out_err_q   <= ERR_APPEND;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
              KIND_DELETE: begin
                if (!range_ok) begin
                  out_inv_q   <= total_q;
                  out_err_q   <= ERR_ABSENT;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
              default: begin
                out_inv_q   <= total_q;
                out_err_q   <= ERR_OK;
              end
            endcase
          end
        end
        ST_SCAN: begin
          step_q  <= step_q + 1'b1;
          hit_q   <= hit_d;
          cnt_a_q <= cnt_a_d;
          cnt_b_q <= cnt_b_d;
          if (last_step) begin
            state_q     <= ST_IDLE;
            if (is_app_q) begin
              if (hit_d) begin
                out_inv_q <= total_q;
                out_err_q <= ERR_APPEND;
              end else begin
                total_q    <= total_q + InvW'(cnt_a_d);
                out_inv_q  <= total_q + InvW'(cnt_a_d);
                out_err_q  <= ERR_OK;
                slot_cnt_q <= slot_cnt_q + 1'b1;
              end
            end else begin
              out_inv_q <= total_q;
              if (hit_d) begin
                out_err_q <= ERR_OK;
                total_q   <= (InvW'(sub) > total_q) ? '0 : total_q - InvW'(sub);
              end else begin
                out_err_q <= ERR_ABSENT;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_err_q, out_inv_q};

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench of the dynamic inversion counter
module tb_top;
  import dic_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  dynamic_inversion_counter dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  typedef struct packed {
    logic [InvW-1:0] inversions;
    err_e            error;
  } outcome_t;

  typedef struct {
    kind_e           kind;
    logic [ValW-1:0] value;
    logic            typed;
    logic [InvW-1:0] inv;
    err_e            err;
  } row_t;

  // predictor state
  logic [ValW-1:0] seq_val [MaxLen];
  logic            seq_live [MaxLen];
  int              pos_of [MaxLen];
  logic            loaded [MaxLen];
  int              used;
  logic [InvW-1:0] total;

  outcome_t pending_q[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  calm = 0;
  row_t plan [$];

  initial clk_i = 0;
  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic void empty_store();
    for (int i = 0; i < MaxLen; i++) begin
      seq_live[i] = 0;
      loaded[i] = 0;
    end
    used = 0;
    total = '0;
  endfunction

  function automatic outcome_t count_step(input kind_e k, input logic [ValW-1:0] v);
    outcome_t o;
    int n;
    int s;
    o.error = ERR_OK;
    n = 0;
    case (k)
      KIND_CLEAR: begin
        empty_store();
      end
      KIND_APPEND: begin
        if (v < 1 || v > MaxLen || loaded[v-1] || used >= MaxLen) o.error = ERR_APPEND;
        else begin
          for (int i = 0; i < used; i++) if (seq_live[i] && seq_val[i] > v) n++;
          seq_val[used] = v;
          seq_live[used] = 1;
          pos_of[v-1] = used;
          loaded[v-1] = 1;
          used++;
          total = total + n[InvW-1:0];
        end
      end
      KIND_DELETE: begin
        if (v < 1 || v > MaxLen || !loaded[v-1]) o.error = ERR_ABSENT;
        else begin
          s = pos_of[v-1];
          for (int i = 0; i < used; i++) begin
            if (seq_live[i] && i < s && seq_val[i] > v) n++;
            else if (seq_live[i] && i > s && seq_val[i] < v) n++;
          end
          seq_live[s] = 0;
          loaded[v-1] = 0;
          o.inversions = total;
          total = (n > total) ? '0 : total - n[InvW-1:0];
          return o;
        end
      end
      default: ;
    endcase
    o.inversions = total;
    return o;
  endfunction

  // evaluates a step without changing the predictor state so that the directed expectation can be compared
  function automatic outcome_t count_step_peek(input kind_e k, input logic [ValW-1:0] v);
    outcome_t o;
    int n;
    int s;
    o.error = ERR_OK;
    o.inversions = total;
    n = 0;
    case (k)
      KIND_CLEAR: o.inversions = '0;
      KIND_APPEND: begin
        if (v < 1 || v > MaxLen || loaded[v-1] || used >= MaxLen) o.error = ERR_APPEND;
        else begin
          for (int i = 0; i < used; i++) if (seq_live[i] && seq_val[i] > v) n++;
          o.inversions = total + n[InvW-1:0];
        end
      end
      KIND_DELETE: if (v < 1 || v > MaxLen || !loaded[v-1]) o.error = ERR_ABSENT;
      default: ;
    endcase
    return o;
  endfunction

  // result side
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) report("unexpected result", 32'(m_axis_tdata), 0);
      else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[18:0] !== want.inversions)
          report("inversions", 32'(m_axis_tdata[18:0]), 32'(want.inversions));
        if (m_axis_tdata[20:19] !== want.error)
          report("error", 32'(m_axis_tdata[20:19]), 32'(want.error));
        if (m_axis_tdata[23:21] !== 3'b0) report("fill", 32'(m_axis_tdata[23:21]), 0);
      end
    end
  end

  always @(negedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 8);

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(input kind_e k, input logic [ValW-1:0] v, input logic [1:0] raw);
    while (!calm && $urandom_range(99) < 8) @(negedge clk_i);
    s_axis_tvalid = 1;
    s_axis_tuser = raw;
    s_axis_tdata = {5'b0, v};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_q.push_back(count_step(k, v));
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  task automatic add_row(input kind_e k, input int v, input bit t, input int inv, input err_e e);
    row_t r;
    r.kind = k; r.value = v[ValW-1:0]; r.typed = t; r.inv = inv[InvW-1:0]; r.err = e;
    plan.push_back(r);
  endtask

  initial begin
    int sent;
    int v;
    int r;
    outcome_t guess;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_CLEAR;
    m_axis_tready = 0;
    rst_ni = 0;
    empty_store();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    add_row(KIND_DELETE, 5, 1, 0, ERR_ABSENT);
    add_row(KIND_APPEND, 0, 1, 0, ERR_APPEND);
    add_row(KIND_APPEND, 1025, 1, 0, ERR_APPEND);
    add_row(KIND_APPEND, 2047, 1, 0, ERR_APPEND);
    add_row(KIND_APPEND, 1024, 1, 0, ERR_OK);
    add_row(KIND_APPEND, 1, 1, 1, ERR_OK);
    add_row(KIND_APPEND, 1024, 1, 1, ERR_APPEND);
    add_row(KIND_APPEND, 512, 1, 2, ERR_OK);
    add_row(KIND_NONE, 7, 1, 2, ERR_OK);
    add_row(KIND_DELETE, 0, 1, 2, ERR_ABSENT);
    add_row(KIND_DELETE, 2047, 1, 2, ERR_ABSENT);
    add_row(KIND_DELETE, 1024, 1, 2, ERR_OK);
    add_row(KIND_APPEND, 1024, 0, 0, ERR_OK);
    add_row(KIND_APPEND, 700, 0, 0, ERR_OK);
    add_row(KIND_DELETE, 512, 0, 0, ERR_OK);
    add_row(KIND_DELETE, 1, 0, 0, ERR_OK);
    add_row(KIND_CLEAR, 1365, 1, 0, ERR_OK);
    add_row(KIND_DELETE, 700, 1, 0, ERR_ABSENT);

    foreach (plan[i]) begin
      if (plan[i].typed) begin
        guess = count_step_peek(plan[i].kind, plan[i].value);
        if (guess.inversions !== plan[i].inv || guess.error !== plan[i].err)
          report("directed row", i, 0);
      end
      send(plan[i].kind, plan[i].value, plan[i].kind);
    end

    // a short descending run of the largest values, back to back
    calm = 1;
    for (int i = MaxLen; i > MaxLen - 16; i--) send(KIND_APPEND, i[ValW-1:0], KIND_APPEND);
    calm = 0;
    send(KIND_APPEND, 1, KIND_APPEND);
    send(KIND_DELETE, 1024, KIND_DELETE);
    send(KIND_APPEND, 1024, KIND_APPEND);
    wait (pending_q.size() == 0);
    send(KIND_CLEAR, 0, KIND_CLEAR);

    sent = 0;
    while (sent < 540) begin
      r = $urandom_range(99);
      if (sent % 90 == 0 && sent != 0) wait (pending_q.size() == 0);
      calm = (sent >= 200 && sent < 260);
      v = $urandom_range(1, 48);
      if (r < 3) send(KIND_CLEAR, ValW'($urandom_range(2047)), KIND_CLEAR);
      else if (r < 5) send(KIND_NONE, ValW'($urandom_range(2047)), KIND_NONE);
      else if (r < 8) send(r[0] ? KIND_APPEND : KIND_DELETE, ValW'($urandom_range(2047)),
                           r[0] ? KIND_APPEND : KIND_DELETE);
      else if (r < 58) send(KIND_APPEND, v[ValW-1:0], KIND_APPEND);
      else send(KIND_DELETE, v[ValW-1:0], KIND_DELETE);
      sent++;
    end
    calm = 0;
    wait (pending_q.size() == 0);
    repeat (2 * MaxLen + 20) @(posedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
